@@ hdl/psg_tone_noise_envelope_mixer_macros.svh @@
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope_mixer_macros.svh
// Assertion helpers for the sound generator. Each macro expects clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_ENVELOPE_MIXER_MACROS_SVH
`define PSG_TONE_NOISE_ENVELOPE_MIXER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, widths, reset values and envelope shape table for the
// three-voice sound generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

	// Voice count default and fixed register layout
	localparam int PSG_VOICES   = 3;
	localparam int OUT_VOICES   = 3;
	localparam int TONE_W       = 12;
	localparam int VOL_W        = 4;
	localparam int FLAG_W       = 3;
	localparam int NOISE_P_W    = 5;
	localparam int NOISE_CNT_W  = 6;
	localparam int LFSR_W       = 17;
	localparam int ENV_P_W      = 16;
	localparam int LEVEL_W      = 5;
	localparam int SHAPE_W      = 4;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = OUT_VOICES * TONE_W;

	localparam logic [LEVEL_W-1:0] ENV_MAX  = 5'd31;
	localparam logic [SHAPE_W-1:0] SHAPE_MASK = 4'hf;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0]          TONE_PERIODS_RST = 36'h001001001;
	localparam logic [NOISE_P_W-1:0]           NOISE_PERIOD_RST = 5'd1;
	localparam logic [ENV_P_W-1:0]             ENV_PERIOD_RST   = 16'd1;
	localparam logic [OUT_VOICES*VOL_W-1:0]    VOLUMES_RST      = '0;
	localparam logic [OUT_VOICES*FLAG_W-1:0]   FLAGS_RST        = '0;
	localparam logic [LFSR_W-1:0]              LFSR_RST         = 17'd1;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TONE_PERIODS    = 3'd0,
		REG_NOISE_PERIOD    = 3'd1,
		REG_ENV_PERIOD      = 3'd2,
		REG_CHANNEL_VOLUMES = 3'd3,
		REG_MIXER_FLAGS     = 3'd4
	} cfg_reg_t;

	// Envelope segment kinds
	typedef enum logic [1:0] {
		SEG_DOWN = 2'd0,
		SEG_UP   = 2'd1,
		SEG_HIGH = 2'd2,
		SEG_LOW  = 2'd3
	} seg_t;

	// Segment kind for a shape and phase (first or second segment)
	function automatic seg_t seg_code(input logic [SHAPE_W-1:0] kind, input logic phase);
		seg_t code;
		case (kind)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd9: code = phase ? SEG_LOW : SEG_DOWN;
			4'd4, 4'd5, 4'd6, 4'd7, 4'd15: code = phase ? SEG_LOW : SEG_UP;
			4'd8:  code = SEG_DOWN;
			4'd10: code = phase ? SEG_UP : SEG_DOWN;
			4'd11: code = phase ? SEG_HIGH : SEG_DOWN;
			4'd12: code = SEG_UP;
			4'd13: code = phase ? SEG_HIGH : SEG_UP;
			4'd14: code = phase ? SEG_DOWN : SEG_UP;
			default: code = SEG_LOW;
		endcase
		return code;
	endfunction

	// Level at which a segment begins
	function automatic logic [LEVEL_W-1:0] seg_start(input seg_t code);
		return (code == SEG_DOWN || code == SEG_HIGH) ? ENV_MAX : '0;
	endfunction

endpackage

@@ hdl/psg_tone_noise_envelope_mixer.sv @@
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope_mixer
// Three-voice sound generator: tone, noise and envelope counters with a
// per-voice gate and level select.
// ----------------------------------------------------------------------------
// The tone, noise and envelope counters all update from one registered pass
// of compare-and-increment logic, and the four levels land in an output
// register in the same edge. A new request is accepted every cycle, also while
// the previous result is being taken; input stall is raised only while a
// finished result sits unclaimed under output stall. out_valid rises in the
// cycle after accept. Configuration writes are registered and should be made
// while no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_tone_noise_envelope_mixer #(
	parameter int VOICES = psg_pkg::PSG_VOICES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [psg_pkg::SHAPE_W-1:0]       shape,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [psg_pkg::LEVEL_W-1:0]       level_a,
	output logic [psg_pkg::LEVEL_W-1:0]       level_b,
	output logic [psg_pkg::LEVEL_W-1:0]       level_c,
	output logic [psg_pkg::LEVEL_W-1:0]       envelope_level,
	// configuration
	input  logic                              cfg_we,
	input  logic [psg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [psg_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import psg_pkg::*;

	`include "psg_tone_noise_envelope_mixer_macros.svh"

	// Configuration registers
	logic [CFG_DATA_W-1:0]         tone_periods_q;
	logic [NOISE_P_W-1:0]          noise_period_q;
	logic [ENV_P_W-1:0]            env_period_q;
	logic [OUT_VOICES*VOL_W-1:0]   volumes_q;
	logic [OUT_VOICES*FLAG_W-1:0]  flags_q;

	// Generator state
	logic [TONE_W-1:0]       tone_cnt_q [VOICES];
	logic [VOICES-1:0]       tone_bit_q;
	logic [NOISE_CNT_W-1:0]  noise_cnt_q;
	logic [LFSR_W-1:0]       lfsr_q;
	logic [ENV_P_W-1:0]      env_cnt_q;
	logic [LEVEL_W-1:0]      env_val_q;
	logic                    env_phase_q;
	logic [SHAPE_W-1:0]      env_kind_q;

	// Next state
	logic [TONE_W-1:0]       tone_cnt_d [VOICES];
	logic [VOICES-1:0]       tone_bit_d;
	logic [NOISE_CNT_W-1:0]  noise_cnt_d;
	logic [LFSR_W-1:0]       lfsr_d;
	logic [ENV_P_W-1:0]      env_cnt_d;
	logic [LEVEL_W-1:0]      env_val_d;
	logic                    env_phase_d;
	logic [SHAPE_W-1:0]      env_kind_d;

	logic [LEVEL_W-1:0]      level_d [OUT_VOICES];

	logic in_acc;
	logic tick;

	// Handshake: output register frees up when empty or being taken
	assign in_stall = out_valid && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign tick     = !op;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_periods_q <= TONE_PERIODS_RST;
			noise_period_q <= NOISE_PERIOD_RST;
			env_period_q   <= ENV_PERIOD_RST;
			volumes_q      <= VOLUMES_RST;
			flags_q        <= FLAGS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TONE_PERIODS:    tone_periods_q <= cfg_data;
				REG_NOISE_PERIOD:    noise_period_q <= cfg_data[NOISE_P_W-1:0];
				REG_ENV_PERIOD:      env_period_q   <= cfg_data[ENV_P_W-1:0];
				REG_CHANNEL_VOLUMES: volumes_q      <= cfg_data[OUT_VOICES*VOL_W-1:0];
				REG_MIXER_FLAGS:     flags_q        <= cfg_data[OUT_VOICES*FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Tone counters: square bit toggles when the count reaches the period
	for (genvar v = 0; v < VOICES; v++) begin : g_tone
		logic [TONE_W-1:0] period;
		logic [TONE_W-1:0] limit;
		logic [TONE_W:0]   sum;
		logic              hit;

		if (v < OUT_VOICES) begin : g_field
			assign period = tone_periods_q[v*TONE_W +: TONE_W];
		end else begin : g_none
			assign period = '0;
		end

		assign limit = (period == '0) ? TONE_W'(1) : period;
		assign sum   = {1'b0, tone_cnt_q[v]} + (TONE_W+1)'(1);
		assign hit   = sum >= {1'b0, limit};

		always_comb begin
			tone_cnt_d[v] = tone_cnt_q[v];
			tone_bit_d[v] = tone_bit_q[v];
			if (tick) begin
				tone_cnt_d[v] = hit ? '0 : sum[TONE_W-1:0];
				tone_bit_d[v] = tone_bit_q[v] ^ hit;
			end
		end
	end

	// Noise: LFSR shifts at twice the noise period
	logic [NOISE_P_W-1:0]    noise_p;
	logic [NOISE_CNT_W-1:0]  noise_lim;
	logic [NOISE_CNT_W:0]    noise_sum;
	logic                    noise_hit;
	logic                    lfsr_fb;

	assign noise_p   = (noise_period_q == '0) ? NOISE_P_W'(1) : noise_period_q;
	assign noise_lim = {noise_p, 1'b0};
	assign noise_sum = {1'b0, noise_cnt_q} + (NOISE_CNT_W+1)'(1);
	assign noise_hit = noise_sum >= {1'b0, noise_lim};
	assign lfsr_fb   = lfsr_q[0] ^ lfsr_q[3];

	always_comb begin
		noise_cnt_d = noise_cnt_q;
		lfsr_d      = lfsr_q;
		if (tick) begin
			noise_cnt_d = noise_hit ? '0 : noise_sum[NOISE_CNT_W-1:0];
			if (noise_hit)
				lfsr_d = {lfsr_fb, lfsr_q[LFSR_W-1:1]};
		end
	end

	// Envelope: step counter, slide/hold segments, restart on shape write
	logic [ENV_P_W-1:0] env_lim;
	logic [ENV_P_W:0]   env_sum;
	logic               env_hit;
	seg_t               env_code;
	seg_t               env_next_code;

	assign env_lim       = (env_period_q == '0) ? ENV_P_W'(1) : env_period_q;
	assign env_sum       = {1'b0, env_cnt_q} + (ENV_P_W+1)'(1);
	assign env_hit       = env_sum >= {1'b0, env_lim};
	assign env_code      = seg_code(env_kind_q, env_phase_q);
	assign env_next_code = seg_code(env_kind_q, !env_phase_q);

	always_comb begin
		env_cnt_d   = env_cnt_q;
		env_val_d   = env_val_q;
		env_phase_d = env_phase_q;
		env_kind_d  = env_kind_q;
		if (!tick) begin
			env_kind_d  = shape;
			env_cnt_d   = '0;
			env_phase_d = 1'b0;
			env_val_d   = seg_start(seg_code(shape, 1'b0));
		end else begin
			env_cnt_d = env_hit ? '0 : env_sum[ENV_P_W-1:0];
			if (env_hit) begin
				case (env_code)
					SEG_DOWN: begin
						if (env_val_q == '0) begin
							env_phase_d = !env_phase_q;
							env_val_d   = seg_start(env_next_code);
						end else begin
							env_val_d = env_val_q - LEVEL_W'(1);
						end
					end
					SEG_UP: begin
						if (env_val_q >= ENV_MAX) begin
							env_phase_d = !env_phase_q;
							env_val_d   = seg_start(env_next_code);
						end else begin
							env_val_d = env_val_q + LEVEL_W'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Per-voice gate and level select, from the updated state
	for (genvar v = 0; v < OUT_VOICES; v++) begin : g_mix
		if (v < VOICES) begin : g_live
			logic [FLAG_W-1:0] fl;
			logic              gate;
			logic [LEVEL_W-1:0] lvl;

			assign fl   = flags_q[v*FLAG_W +: FLAG_W];
			assign gate = (tone_bit_d[v] | fl[0]) & (lfsr_d[0] | fl[1]);
			assign lvl  = fl[2] ? env_val_d : {volumes_q[v*VOL_W +: VOL_W], 1'b1};
			assign level_d[v] = gate ? lvl : '0;
		end else begin : g_absent
			assign level_d[v] = '0;
		end
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++)
				tone_cnt_q[i] <= '0;
			tone_bit_q  <= '0;
			noise_cnt_q <= '0;
			lfsr_q      <= LFSR_RST;
			env_cnt_q   <= '0;
			env_val_q   <= '0;
			env_phase_q <= 1'b0;
			env_kind_q  <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (in_acc) begin
				for (int i = 0; i < VOICES; i++)
					tone_cnt_q[i] <= tone_cnt_d[i];
				tone_bit_q  <= tone_bit_d;
				noise_cnt_q <= noise_cnt_d;
				lfsr_q      <= lfsr_d;
				env_cnt_q   <= env_cnt_d;
				env_val_q   <= env_val_d;
				env_phase_q <= env_phase_d;
				env_kind_q  <= env_kind_d;
				out_valid   <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload, loaded only with a new request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			level_a        <= level_d[0];
			level_b        <= level_d[1];
			level_c        <= level_d[2];
			envelope_level <= env_val_d;
		end
	end

	// Checks
	`PSG_ASSERT_NOW(a_env_out_match, out_valid, envelope_level == env_val_q,
		"envelope level output differs from envelope state")
	`PSG_ASSERT_NEXT(a_shape_restart, in_acc && op, env_cnt_q == '0 && !env_phase_q,
		"shape write did not restart the envelope")
	`PSG_ASSERT_NOW(a_lfsr_nonzero, 1'b1, lfsr_q != '0,
		"noise LFSR reached the all-zero lockup state")
	`PSG_ASSERT_NEXT(a_drain, out_valid && !out_stall && !in_acc, !out_valid,
		"result stayed valid after it was taken")

endmodule
